@@ rtl/core/delta_timestamp_log_framer_core_assert.svh @@
// Assertion macros for the delta timestamp log framer core.
`ifndef DELTA_TIMESTAMP_LOG_FRAMER_CORE_ASSERT_SVH
`define DELTA_TIMESTAMP_LOG_FRAMER_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define DTLF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dtlf assertion failed");

// Antecedent implies consequent in the next cycle.
`define DTLF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dtlf assertion failed");

`endif

@@ rtl/core/dtlf_pkg.sv @@
// Package: constants and codes of the delta timestamp log framer core.
package dtlf_pkg;

    localparam int DATA_BYTES = 4;
    localparam int TIME_BYTES = 8;

    localparam int TS_W      = 48;
    localparam int SMP_W     = 32;
    localparam int DIV_W     = 16;
    localparam int DENS_W    = 8;
    localparam int OFS_W     = 32;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int KIND_W    = 2;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 120;

    localparam int DIV_STEPS = TS_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRAILER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_INDEX   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_DIVISOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_ENABLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_DENSITY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ENTRIES = 3'd4;

    localparam logic [DIV_W-1:0]  RST_DELTA_DIVISOR = 16'd1;
    localparam logic              RST_INDEX_ENABLE  = 1'b1;
    localparam logic [DENS_W-1:0] RST_INDEX_DENSITY = 8'd5;

endpackage

@@ rtl/core/delta_timestamp_log_framer_core.sv @@
// Top level: delta timestamp log framer with a shared iterative divider.
// An input transfer is taken only when the core is idle. A sample that opens a
// new entry with none open emits a header and then the sample record. A
// sample into an open entry runs a 48-step restoring division of the time
// difference by the divisor (one quotient bit per cycle), a rounding step and
// a result step. Closing an entry with index records enabled runs the same
// divider again for the entry total modulo the density, so the worst case, a
// sample that closes an entry with an index record and opens the next, emits
// four results; output stalls can hold each of them. No clearing pass after
// reset is needed.
`include "delta_timestamp_log_framer_core_assert.svh"

module delta_timestamp_log_framer_core #(
    parameter int DATA_BYTES = dtlf_pkg::DATA_BYTES,
    parameter int TIME_BYTES = dtlf_pkg::TIME_BYTES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [dtlf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // timestamp, sample
    input  logic                               s_axis_tuser,  // mode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // time_value, data_word, small_value, byte_location
    output logic [dtlf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [dtlf_pkg::KIND_W-1:0]        m_axis_tuser,  // kind
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dtlf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dtlf_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROUND,
        ST_MOD,
        ST_TRL,
        ST_IDX,
        ST_HDR,
        ST_SMP
    } t_state;

    t_state r_state;

    logic [dtlf_pkg::DIV_W-1:0]  r_delta_divisor;
    logic                        r_index_enable;
    logic [dtlf_pkg::DENS_W-1:0] r_index_density;

    logic                        r_open;
    logic [dtlf_pkg::TS_W-1:0]   r_etime;
    logic [dtlf_pkg::CNT_W-1:0]  r_count;
    logic [dtlf_pkg::OFS_W-1:0]  r_estart;
    logic [dtlf_pkg::OFS_W-1:0]  r_etotal;

    logic [dtlf_pkg::TS_W-1:0]   r_ts;
    logic [dtlf_pkg::SMP_W-1:0]  r_smp;
    logic                        r_hdr_pending;
    logic                        r_fresh;
    logic                        r_idx;
    logic [dtlf_pkg::CNT_W-1:0]  r_delta;

    logic                        r_op_mod;
    logic [dtlf_pkg::TS_W-1:0]   r_dvd;
    logic [dtlf_pkg::DIV_W-1:0]  r_rem;
    logic [dtlf_pkg::STEP_W-1:0] r_step;

    logic                          r_m_valid;
    logic [dtlf_pkg::KIND_W-1:0]   r_m_kind;
    logic [dtlf_pkg::TS_W-1:0]     r_m_time;
    logic [dtlf_pkg::SMP_W-1:0]    r_m_word;
    logic [dtlf_pkg::CNT_W-1:0]    r_m_small;
    logic [dtlf_pkg::OFS_W-1:0]    r_m_loc;
    logic                          r_m_last;

    logic                        w_in_fire;
    logic                        w_out_free;
    logic                        w_emit;
    logic                        w_mod_on;
    logic [dtlf_pkg::TS_W-1:0]   w_in_ts;
    logic [dtlf_pkg::SMP_W-1:0]  w_in_smp;
    logic [dtlf_pkg::DIV_W-1:0]  w_dvs;
    logic [dtlf_pkg::DIV_W:0]    w_shift;
    logic                        w_ge;
    logic [dtlf_pkg::DIV_W-1:0]  w_rem_next;
    logic                        w_inc;
    logic                        w_big;
    logic [dtlf_pkg::OFS_W-1:0]  w_entry_size;
    logic [dtlf_pkg::OFS_W-1:0]  w_total_inc;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign w_emit        = w_out_free && (r_state inside {ST_TRL, ST_IDX, ST_HDR, ST_SMP});
    assign w_mod_on      = r_index_enable && (r_index_density != '0);
    assign w_in_ts       = s_axis_tdata[dtlf_pkg::TS_W-1:0];
    assign w_in_smp      = s_axis_tdata[dtlf_pkg::TS_W +: dtlf_pkg::SMP_W];
    assign w_total_inc   = r_etotal + 32'd1;

    // Shared restoring divider step.
    always_comb begin
        if (r_op_mod) begin
            w_dvs = {{(dtlf_pkg::DIV_W-dtlf_pkg::DENS_W){1'b0}}, r_index_density};
        end else if (r_delta_divisor == '0) begin
            w_dvs = 16'd1;
        end else begin
            w_dvs = r_delta_divisor;
        end
    end

    assign w_shift    = {r_rem, r_dvd[dtlf_pkg::TS_W-1]};
    assign w_ge       = (w_shift >= {1'b0, w_dvs});
    assign w_rem_next = w_ge ? 16'(w_shift - {1'b0, w_dvs}) : w_shift[dtlf_pkg::DIV_W-1:0];

    assign w_inc = ({r_rem, 1'b0} > {1'b0, w_dvs});
    assign w_big = (r_dvd[dtlf_pkg::TS_W-1:dtlf_pkg::CNT_W] != '0) ||
                   ((r_dvd[dtlf_pkg::CNT_W-1:0] == 8'hFF) && w_inc);

    assign w_entry_size = 32'(TIME_BYTES + 1) +
                          32'({1'b0, r_count} + 9'd1) * 32'(DATA_BYTES + 1);

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_loc, r_m_small, r_m_word, r_m_time};
    assign m_axis_tuser  = r_m_kind;
    assign m_axis_tlast  = r_m_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_delta_divisor <= dtlf_pkg::RST_DELTA_DIVISOR;
            r_index_enable  <= dtlf_pkg::RST_INDEX_ENABLE;
            r_index_density <= dtlf_pkg::RST_INDEX_DENSITY;
            r_open          <= 1'b0;
            r_etime         <= '0;
            r_count         <= '0;
            r_estart        <= '0;
            r_etotal        <= '0;
            r_hdr_pending   <= 1'b0;
            r_fresh         <= 1'b0;
            r_idx           <= 1'b0;
            r_op_mod        <= 1'b0;
            r_step          <= '0;
            r_m_valid       <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready && !w_emit) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_fire) begin
                        r_ts          <= w_in_ts;
                        r_smp         <= w_in_smp;
                        r_hdr_pending <= 1'b0;
                        r_fresh       <= 1'b0;
                        if (s_axis_tuser) begin
                            if (r_open) begin
                                if (w_mod_on) begin
                                    r_op_mod <= 1'b1;
                                    r_dvd    <= {16'd0, w_total_inc};
                                    r_rem    <= '0;
                                    r_step   <= dtlf_pkg::STEP_W'(dtlf_pkg::DIV_STEPS - 1);
                                    r_state  <= ST_MOD;
                                end else begin
                                    r_idx   <= 1'b0;
                                    r_state <= ST_TRL;
                                end
                            end
                        end else if (r_open) begin
                            r_op_mod <= 1'b0;
                            r_dvd    <= w_in_ts - r_etime;
                            r_rem    <= '0;
                            r_step   <= dtlf_pkg::STEP_W'(dtlf_pkg::DIV_STEPS - 1);
                            r_state  <= ST_DIV;
                        end else begin
                            r_state <= ST_HDR;
                        end
                    end
                end
                ST_DIV: begin
                    r_dvd  <= {r_dvd[dtlf_pkg::TS_W-2:0], w_ge};
                    r_rem  <= w_rem_next;
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    if (w_big || (r_count == 8'hFF)) begin
                        r_hdr_pending <= 1'b1;
                        if (w_mod_on) begin
                            r_op_mod <= 1'b1;
                            r_dvd    <= {16'd0, w_total_inc};
                            r_rem    <= '0;
                            r_step   <= dtlf_pkg::STEP_W'(dtlf_pkg::DIV_STEPS - 1);
                            r_state  <= ST_MOD;
                        end else begin
                            r_idx   <= 1'b0;
                            r_state <= ST_TRL;
                        end
                    end else begin
                        r_delta <= r_dvd[dtlf_pkg::CNT_W-1:0] + {7'd0, w_inc};
                        r_state <= ST_SMP;
                    end
                end
                ST_MOD: begin
                    r_dvd  <= {r_dvd[dtlf_pkg::TS_W-2:0], w_ge};
                    r_rem  <= w_rem_next;
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_idx   <= (w_rem_next == 16'd1);
                        r_state <= ST_TRL;
                    end
                end
                ST_TRL: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_kind  <= dtlf_pkg::KIND_TRAILER;
                        r_m_time  <= '0;
                        r_m_word  <= '0;
                        r_m_small <= r_count;
                        r_m_loc   <= '0;
                        r_m_last  <= !r_idx && !r_hdr_pending;
                        r_etotal  <= w_total_inc;
                        if (r_idx) begin
                            r_state <= ST_IDX;
                        end else begin
                            r_estart <= r_estart + w_entry_size;
                            r_open   <= 1'b0;
                            r_state  <= r_hdr_pending ? ST_HDR : ST_IDLE;
                        end
                    end
                end
                ST_IDX: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_kind  <= dtlf_pkg::KIND_INDEX;
                        r_m_time  <= r_etime;
                        r_m_word  <= '0;
                        r_m_small <= '0;
                        r_m_loc   <= r_estart;
                        r_m_last  <= !r_hdr_pending;
                        r_estart  <= r_estart + w_entry_size;
                        r_open    <= 1'b0;
                        r_state   <= r_hdr_pending ? ST_HDR : ST_IDLE;
                    end
                end
                ST_HDR: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_kind  <= dtlf_pkg::KIND_HEADER;
                        r_m_time  <= r_ts;
                        r_m_word  <= '0;
                        r_m_small <= '0;
                        r_m_loc   <= '0;
                        r_m_last  <= 1'b0;
                        r_etime   <= r_ts;
                        r_open    <= 1'b1;
                        r_fresh   <= 1'b1;
                        r_delta   <= '0;
                        r_state   <= ST_SMP;
                    end
                end
                ST_SMP: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_kind  <= dtlf_pkg::KIND_SAMPLE;
                        r_m_time  <= '0;
                        r_m_word  <= r_smp;
                        r_m_small <= r_delta;
                        r_m_loc   <= '0;
                        r_m_last  <= 1'b1;
                        r_count   <= r_fresh ? '0 : r_count + 8'd1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    dtlf_pkg::CFG_DELTA_DIVISOR: begin
                        r_delta_divisor <= i_cfg_data[dtlf_pkg::DIV_W-1:0];
                    end
                    dtlf_pkg::CFG_INDEX_ENABLE: begin
                        r_index_enable <= i_cfg_data[0];
                    end
                    dtlf_pkg::CFG_INDEX_DENSITY: begin
                        r_index_density <= i_cfg_data[dtlf_pkg::DENS_W-1:0];
                    end
                    dtlf_pkg::CFG_BASE_OFFSET: begin
                        r_estart <= i_cfg_data[dtlf_pkg::OFS_W-1:0];
                    end
                    dtlf_pkg::CFG_INITIAL_ENTRIES: begin
                        r_etotal <= i_cfg_data[dtlf_pkg::OFS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    `DTLF_ASSERT_SAME(a_sample_is_last, m_axis_tvalid && (m_axis_tuser == dtlf_pkg::KIND_SAMPLE), m_axis_tlast)
    `DTLF_ASSERT_SAME(a_header_not_last, m_axis_tvalid && (m_axis_tuser == dtlf_pkg::KIND_HEADER), !m_axis_tlast)
    `DTLF_ASSERT_SAME(a_smp_entry_open, r_state == ST_SMP, r_open)
    `DTLF_ASSERT_NEXT(a_div_flow, r_state == ST_DIV, (r_state == ST_DIV) || (r_state == ST_ROUND))
    `DTLF_ASSERT_SAME(a_close_needs_open, (r_state == ST_TRL) || (r_state == ST_MOD), r_open)

endmodule

@@ dv/tb_delta_timestamp_log_framer_core.sv @@
// Testbench for the delta timestamp log framer core: samples and flushes checked per record.
`timescale 1ns / 1ps

module tb_delta_timestamp_log_framer_core;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 250;
    localparam int HOLD_CYCLES  = 600;

    typedef struct packed {
        logic                       mode;
        logic [dtlf_pkg::TS_W-1:0]  ts;
        logic [dtlf_pkg::SMP_W-1:0] smp;
    } t_log_item;

    typedef struct packed {
        logic [dtlf_pkg::KIND_W-1:0] kind;
        logic [dtlf_pkg::TS_W-1:0]   tv;
        logic [dtlf_pkg::SMP_W-1:0]  dw;
        logic [dtlf_pkg::CNT_W-1:0]  sv;
        logic [dtlf_pkg::OFS_W-1:0]  bl;
        logic                        last;
    } t_log_record;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [dtlf_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             s_axis_tuser = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [dtlf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [dtlf_pkg::KIND_W-1:0]      m_axis_tuser;
    logic                             m_axis_tlast;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [dtlf_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [dtlf_pkg::CFG_DAT_W-1:0]   i_cfg_data = '0;

    delta_timestamp_log_framer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // register copies
    logic [dtlf_pkg::DIV_W-1:0]  cfg_div  = dtlf_pkg::RST_DELTA_DIVISOR;
    logic                        cfg_en   = dtlf_pkg::RST_INDEX_ENABLE;
    logic [dtlf_pkg::DENS_W-1:0] cfg_dens = dtlf_pkg::RST_INDEX_DENSITY;

    // framing state
    logic                        st_open  = 1'b0;
    logic [dtlf_pkg::TS_W-1:0]   st_time  = '0;
    logic [dtlf_pkg::CNT_W-1:0]  st_count = '0;
    logic [dtlf_pkg::OFS_W-1:0]  st_start = '0;
    logic [dtlf_pkg::OFS_W-1:0]  st_total = '0;

    t_log_item   pending_items[$];
    t_log_record expected_records[$];
    t_log_item   cur_item = '0;
    logic        offering = 1'b0;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int hold_cnt = 0;

    int err_count = 0;
    int items_sent = 0;
    int records_seen = 0;
    int cfg_writes = 0;
    int cycles = 0;

    function automatic logic [63:0] scale_delta(input logic [dtlf_pkg::TS_W-1:0] diff);
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        d = (cfg_div == '0) ? 64'd1 : 64'(cfg_div);
        q = 64'(diff) / d;
        r = 64'(diff) % d;
        if (d - r < r) q = q + 64'd1;
        return q;
    endfunction

    task automatic add_record(input logic [dtlf_pkg::KIND_W-1:0] kind,
                              input logic [dtlf_pkg::TS_W-1:0] tv,
                              input logic [dtlf_pkg::SMP_W-1:0] dw,
                              input logic [dtlf_pkg::CNT_W-1:0] sv,
                              input logic [dtlf_pkg::OFS_W-1:0] bl);
        t_log_record rec;
        rec.kind = kind;
        rec.tv = tv;
        rec.dw = dw;
        rec.sv = sv;
        rec.bl = bl;
        rec.last = 1'b0;
        expected_records.push_back(rec);
    endtask

    task automatic close_entry();
        add_record(dtlf_pkg::KIND_TRAILER, '0, '0, st_count, '0);
        st_total = st_total + 32'd1;
        if (cfg_en && cfg_dens != '0 && (st_total % 32'(cfg_dens)) == 32'd1)
            add_record(dtlf_pkg::KIND_INDEX, st_time, '0, '0, st_start);
        st_start = st_start + 32'(dtlf_pkg::TIME_BYTES +
                                  (int'(st_count) + 1) * (dtlf_pkg::DATA_BYTES + 1) + 1);
        st_open = 1'b0;
    endtask

    task automatic frame_item(input t_log_item it);
        logic [63:0]               dq;
        logic [dtlf_pkg::TS_W-1:0] diff;
        logic                      fresh;
        int                        n0;
        t_log_record               tail;
        n0 = expected_records.size();
        if (it.mode) begin
            if (st_open) close_entry();
        end else begin
            fresh = 1'b0;
            dq = '0;
            if (st_open) begin
                diff = it.ts - st_time;
                dq = scale_delta(diff);
            end
            if (!st_open || dq >= 64'd256 || st_count >= 8'd255) begin
                if (st_open) close_entry();
                st_time = it.ts;
                st_open = 1'b1;
                fresh = 1'b1;
                dq = '0;
                add_record(dtlf_pkg::KIND_HEADER, st_time, '0, '0, '0);
            end
            add_record(dtlf_pkg::KIND_SAMPLE, '0, it.smp, dq[dtlf_pkg::CNT_W-1:0], '0);
            st_count = fresh ? 8'd0 : st_count + 8'd1;
        end
        if (expected_records.size() > n0) begin
            tail = expected_records.pop_back();
            tail.last = 1'b1;
            expected_records.push_back(tail);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
        end else begin
            if (offering && s_axis_tready) begin
                frame_item(cur_item);
                offering = 1'b0;
                items_sent++;
            end
            if (!offering && pending_items.size() > 0 &&
                $urandom_range(0, 99) >= snd_idle_pct) begin
                cur_item = pending_items.pop_front();
                offering = 1'b1;
            end
            s_axis_tvalid <= offering;
            s_axis_tdata  <= {cur_item.smp, cur_item.ts};
            s_axis_tuser  <= cur_item.mode;
        end
    end

    // count the receiver hold-off
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt >= HOLD_CYCLES - 1) hold_done <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_log_record exp_rec;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                records_seen++;
                if (expected_records.size() == 0) begin
                    $error("unexpected record kind %0d tdata %0h", m_axis_tuser, m_axis_tdata);
                    err_count++;
                end else begin
                    exp_rec = expected_records.pop_front();
                    if (m_axis_tuser !== exp_rec.kind) begin
                        $error("kind expected %0d actual %0d", exp_rec.kind, m_axis_tuser);
                        err_count++;
                    end
                    if (m_axis_tdata[47:0] !== exp_rec.tv) begin
                        $error("time_value expected %0h actual %0h",
                               exp_rec.tv, m_axis_tdata[47:0]);
                        err_count++;
                    end
                    if (m_axis_tdata[79:48] !== exp_rec.dw) begin
                        $error("data_word expected %0h actual %0h",
                               exp_rec.dw, m_axis_tdata[79:48]);
                        err_count++;
                    end
                    if (m_axis_tdata[87:80] !== exp_rec.sv) begin
                        $error("small_value expected %0h actual %0h",
                               exp_rec.sv, m_axis_tdata[87:80]);
                        err_count++;
                    end
                    if (m_axis_tdata[119:88] !== exp_rec.bl) begin
                        $error("byte_location expected %0h actual %0h",
                               exp_rec.bl, m_axis_tdata[119:88]);
                        err_count++;
                    end
                    if (m_axis_tlast !== exp_rec.last) begin
                        $error("last expected %0d actual %0d", exp_rec.last, m_axis_tlast);
                        err_count++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [dtlf_pkg::TS_W-1:0] rand_ts();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic push_sample(input logic [dtlf_pkg::TS_W-1:0] ts,
                               input logic [dtlf_pkg::SMP_W-1:0] smp);
        t_log_item it;
        it.mode = 1'b0;
        it.ts = ts;
        it.smp = smp;
        pending_items.push_back(it);
    endtask

    task automatic push_flush();
        t_log_item it;
        it.mode = 1'b1;
        it.ts = rand_ts();
        it.smp = $urandom;
        pending_items.push_back(it);
    endtask

    task automatic write_reg(input logic [dtlf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dtlf_pkg::CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            dtlf_pkg::CFG_DELTA_DIVISOR:   cfg_div = val[dtlf_pkg::DIV_W-1:0];
            dtlf_pkg::CFG_INDEX_ENABLE:    cfg_en = val[0];
            dtlf_pkg::CFG_INDEX_DENSITY:   cfg_dens = val[dtlf_pkg::DENS_W-1:0];
            dtlf_pkg::CFG_BASE_OFFSET:     st_start = val;
            dtlf_pkg::CFG_INITIAL_ENTRIES: st_total = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || offering || expected_records.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly well-formed entries with random content, plus stray flushes and wild timestamps
    task automatic gen_traffic(input int n_items);
        int n;
        int k;
        logic [dtlf_pkg::TS_W-1:0] t0;
        logic [dtlf_pkg::TS_W-1:0] d;
        n = 0;
        while (n < n_items) begin
            d = (cfg_div == '0) ? 48'd1 : 48'(cfg_div);
            if ($urandom_range(0, 5) == 0) begin
                if ($urandom_range(0, 1) == 0) push_flush();
                else push_sample(rand_ts(), $urandom);
                n++;
            end else begin
                t0 = rand_ts();
                k = $urandom_range(1, 10);
                repeat (k) begin
                    if ($urandom_range(0, 9) == 0)
                        push_sample(t0 - 48'($urandom_range(1, 1000)), $urandom);
                    else
                        push_sample(t0 + 48'($urandom_range(0, 255)) * d +
                                    48'($urandom_range(0, int'(d) - 1)), $urandom);
                    n++;
                end
                if ($urandom_range(0, 1) == 0) begin
                    push_flush();
                    n++;
                end
            end
        end
    endtask

    initial begin
        logic [dtlf_pkg::TS_W-1:0] t0;
        st_start = '0;
        st_total = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: rounding ties, delta overflow, backward time, wrap of time and offset
        write_reg(dtlf_pkg::CFG_DELTA_DIVISOR, 32'd4);
        write_reg(dtlf_pkg::CFG_INDEX_ENABLE, 32'd1);
        write_reg(dtlf_pkg::CFG_INDEX_DENSITY, 32'd2);
        write_reg(dtlf_pkg::CFG_BASE_OFFSET, 32'hFFFF_FFF0);
        write_reg(dtlf_pkg::CFG_INITIAL_ENTRIES, 32'hFFFF_FFFF);
        push_flush();
        push_sample(48'd0, 32'h0000_0000);
        push_sample(48'd6, 32'hFFFF_FFFF);
        push_sample(48'd7, 32'hA5A5_A5A5);
        push_sample(48'd1021, 32'h5A5A_5A5A);
        push_sample(48'd1022, 32'h1234_5678);
        push_sample(48'd1023, 32'h8765_4321);
        push_sample(48'd1000, 32'hDEAD_BEEF);
        push_flush();
        push_flush();
        push_sample(48'hFFFF_FFFF_FFFF, 32'h0F0F_0F0F);
        push_sample(48'd3, 32'hF0F0_F0F0);
        push_flush();
        drain();

        write_reg(dtlf_pkg::CFG_DELTA_DIVISOR, 32'd0);
        write_reg(dtlf_pkg::CFG_INDEX_DENSITY, 32'd1);
        push_sample(48'd100, 32'h1111_1111);
        push_sample(48'd110, 32'h2222_2222);
        push_flush();
        drain();
        write_reg(dtlf_pkg::CFG_INDEX_DENSITY, 32'd0);
        push_sample(48'd5, 32'h3333_3333);
        push_flush();
        drain();

        write_reg(dtlf_pkg::CFG_DELTA_DIVISOR, 32'd65535);
        write_reg(dtlf_pkg::CFG_INDEX_ENABLE, 32'd0);
        write_reg(dtlf_pkg::CFG_INDEX_DENSITY, 32'd255);
        t0 = rand_ts();
        push_sample(t0, $urandom);
        push_sample(t0 + 48'd65535 * 48'd255 + 48'd32767, $urandom);
        push_sample(t0 + 48'd65535 * 48'd255 + 48'd32768, $urandom);
        push_flush();
        drain();

        // random, sender idles lightly, receiver heavily; pause halfway until drained
        snd_idle_pct = 32;
        rcv_idle_pct = 87;
        write_reg(dtlf_pkg::CFG_DELTA_DIVISOR, 32'($urandom_range(1, 300)));
        write_reg(dtlf_pkg::CFG_INDEX_ENABLE, 32'd1);
        write_reg(dtlf_pkg::CFG_INDEX_DENSITY, 32'($urandom_range(2, 6)));
        write_reg(dtlf_pkg::CFG_BASE_OFFSET, $urandom);
        write_reg(dtlf_pkg::CFG_INITIAL_ENTRIES, $urandom);
        gen_traffic(30);
        drain();
        gen_traffic(30);
        drain();

        snd_idle_pct = 87;
        rcv_idle_pct = 32;
        write_reg(dtlf_pkg::CFG_DELTA_DIVISOR, 32'd1);
        write_reg(dtlf_pkg::CFG_INDEX_DENSITY, 32'd2);
        write_reg(dtlf_pkg::CFG_BASE_OFFSET, 32'd0);
        write_reg(dtlf_pkg::CFG_INITIAL_ENTRIES, 32'd0);
        gen_traffic(60);
        drain();

        // no idling; long receiver hold-off while items keep coming
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_reg(dtlf_pkg::CFG_DELTA_DIVISOR, 32'($urandom_range(1000, 65535)));
        write_reg(dtlf_pkg::CFG_INDEX_ENABLE, 32'($urandom_range(0, 1)));
        write_reg(dtlf_pkg::CFG_INDEX_DENSITY, 32'd3);
        write_reg(dtlf_pkg::CFG_BASE_OFFSET, $urandom);
        hold_req = 1'b1;
        gen_traffic(60);
        drain();

        if (expected_records.size() != 0) begin
            $error("%0d expected records never arrived", expected_records.size());
            err_count++;
        end
        $display("run covered %0d input transfers, %0d output records, %0d register writes",
                 items_sent, records_seen, cfg_writes);
        $display("directed rounding and wrap cases, three idle profiles, receiver hold-off");
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
